@@ rtl/fcg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared constants, types and arithmetic helpers of the chaos-game step engine.
// ----------------------------------------------------------------------------
package fcg_pkg;

  localparam int NUM_MAPS     = 4;
  localparam int CORDIC_STEPS = 24;
  localparam int MAP_W        = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
  localparam int COEF_N       = NUM_MAPS * 6;
  localparam int COEF_W       = $clog2(COEF_N);
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int MOD_STEPS    = 5;
  localparam int PC_W         = 5;
  localparam int MAC1_LAST    = 10;
  localparam int MAC2_FIRST   = 11;
  localparam int MAC2_LAST    = 19;

  localparam logic signed [31:0] TWO_PI_Q   = 32'sd105414357;
  localparam logic signed [31:0] PI_Q       = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q  = 32'sd26353589;
  localparam logic signed [33:0] CORDIC_GAIN_Q = 34'sd10188014;
  localparam logic signed [32:0] Q_ONE      = 33'sd16777216;

  // Item kinds
  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_ITER   = 2'd2;
  localparam logic [1:0] FN_FINISH = 2'd3;

  // Table slots
  localparam logic [2:0] SLOT_PROB  = 3'd0;
  localparam logic [2:0] SLOT_COLOR = 3'd7;

  // Register indexes
  localparam logic [7:0] CFG_SWIRL    = 8'd0;
  localparam logic [7:0] CFG_IDENTITY = 8'd1;
  localparam logic [7:0] CFG_WIDTH    = 8'd2;
  localparam logic [7:0] CFG_HEIGHT   = 8'd3;

  // Multiplier operand pairs
  localparam logic [3:0] M_NONE = 4'd0;
  localparam logic [3:0] M_AX   = 4'd1;
  localparam logic [3:0] M_BY   = 4'd2;
  localparam logic [3:0] M_DX   = 4'd3;
  localparam logic [3:0] M_EY   = 4'd4;
  localparam logic [3:0] M_FXFY = 4'd5;
  localparam logic [3:0] M_RR   = 4'd6;
  localparam logic [3:0] M_FXS  = 4'd7;
  localparam logic [3:0] M_FYC  = 4'd8;
  localparam logic [3:0] M_FXC  = 4'd9;
  localparam logic [3:0] M_FYS  = 4'd10;
  localparam logic [3:0] M_SXW  = 4'd11;
  localparam logic [3:0] M_FXI  = 4'd12;
  localparam logic [3:0] M_SYW  = 4'd13;
  localparam logic [3:0] M_FYI  = 4'd14;

  // Accumulator operations
  localparam logic [2:0] A_HOLD = 3'd0;
  localparam logic [2:0] A_P    = 3'd1;
  localparam logic [2:0] A_ADDP = 3'd2;
  localparam logic [2:0] A_SUBP = 3'd3;
  localparam logic [2:0] A_ADDK = 3'd4;

  // Accumulator destinations
  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_FX   = 3'd1;
  localparam logic [2:0] D_FY   = 3'd2;
  localparam logic [2:0] D_R    = 3'd3;
  localparam logic [2:0] D_SX   = 3'd4;
  localparam logic [2:0] D_SY   = 3'd5;
  localparam logic [2:0] D_X    = 3'd6;
  localparam logic [2:0] D_Y    = 3'd7;

  typedef struct packed {
    logic [3:0] mul;
    logic [2:0] kn;
    logic [2:0] op;
    logic [2:0] dest;
  } uop_t;

  typedef struct packed {
    logic [7:0]         under_blue;
    logic [7:0]         under_green;
    logic [7:0]         under_red;
    logic [15:0]        rand_u;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_x;
    logic signed [31:0] word;
    logic [2:0]         slot;
    logic [1:0]         entry;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
    logic [1:0]         chosen_entry;
    logic               on_image;
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } out_item_t;

  typedef struct packed {
    logic              latch;
    logic              sel_step;
    logic [MAP_W-1:0]  sel_k;
    logic              mac_en;
    logic [PC_W-1:0]   pc;
    logic              mod_init;
    logic              mod_step;
    logic [2:0]        mod_k;
    logic              fold;
    logic              cordic_step;
    logic [STEP_W-1:0] cordic_i;
    logic              loc_x;
    logic              loc_y;
    logic              fin;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sel_hit;
  } stat_t;

  // Multiply-accumulate program: affine map and r^2, then swirl and weights
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{M_NONE, 3'd0, A_HOLD, D_NONE};
    case (pc)
      5'd0:  u = '{M_AX,   3'd0, A_HOLD, D_NONE};
      5'd1:  u = '{M_BY,   3'd1, A_P,    D_NONE};
      5'd2:  u = '{M_DX,   3'd3, A_ADDP, D_NONE};
      5'd3:  u = '{M_NONE, 3'd2, A_ADDK, D_FX};
      5'd4:  u = '{M_EY,   3'd4, A_P,    D_NONE};
      5'd5:  u = '{M_NONE, 3'd0, A_ADDP, D_NONE};
      5'd6:  u = '{M_NONE, 3'd5, A_ADDK, D_FY};
      5'd7:  u = '{M_FXFY, 3'd0, A_HOLD, D_NONE};
      5'd8:  u = '{M_NONE, 3'd0, A_P,    D_R};
      5'd9:  u = '{M_RR,   3'd0, A_HOLD, D_NONE};
      5'd10: u = '{M_NONE, 3'd0, A_P,    D_R};
      5'd11: u = '{M_FXS,  3'd0, A_HOLD, D_NONE};
      5'd12: u = '{M_FYC,  3'd0, A_P,    D_NONE};
      5'd13: u = '{M_FXC,  3'd0, A_SUBP, D_SX};
      5'd14: u = '{M_FYS,  3'd0, A_P,    D_NONE};
      5'd15: u = '{M_SXW,  3'd0, A_ADDP, D_SY};
      5'd16: u = '{M_FXI,  3'd0, A_P,    D_NONE};
      5'd17: u = '{M_SYW,  3'd0, A_ADDP, D_X};
      5'd18: u = '{M_FYI,  3'd0, A_P,    D_NONE};
      5'd19: u = '{M_NONE, 3'd0, A_ADDP, D_Y};
      default: u = '{M_NONE, 3'd0, A_HOLD, D_NONE};
    endcase
    return u;
  endfunction

  // Arctangent of 2^-i in Q8.24
  function automatic logic signed [31:0] atan_q(input logic [5:0] i);
    logic signed [31:0] v;
    logic [4:0]         sh;
    sh = 5'(6'd24 - i);
    case (i)
      6'd0: v = 32'sd13176795;
      6'd1: v = 32'sd7778716;
      6'd2: v = 32'sd4110060;
      6'd3: v = 32'sd2086331;
      6'd4: v = 32'sd1047214;
      6'd5: v = 32'sd524117;
      6'd6: v = 32'sd262123;
      6'd7: v = 32'sd131069;
      default: v = (i <= 6'd24) ? (32'sd1 <<< sh) : 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/flame_chaos_game_step.sv @@
`timescale 1ns / 1ps
// Load, start and finish words go from accept through pixel mapping, colour
// update and result load; an iterate word also runs the map scan (1 to NUM_MAPS),
// the 20-step multiply program on one 32x32 multiplier, 5 reduction steps and
// the CORDIC_STEPS rotation loop. One word is in work at a time: a new word is
// taken once the last result is loaded, later while an untaken result blocks.
// Reset (rst, synchronous, active high) clears table and state, loads defaults.
// ----------------------------------------------------------------------------
// flame_chaos_game_step
// Fractal-flame chaos-game step engine: stream in, stream out, config port.
// ----------------------------------------------------------------------------
module flame_chaos_game_step (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry, slot, word, coord_x, coord_y, rand_u, under_red, under_green,
  // under_blue, zero pad
  input  logic [143:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y, pixel_col, pixel_row, on_image, chosen_entry, out_red,
  // out_green, out_blue, zero pad
  output logic [119:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import fcg_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item   = s_tdata[140:0];
  assign m_tdata   = {5'd0, out_item};
  assign cfg_ready = 1'b1;

  fcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_tuser),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

  // one word in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

  // a result is loaded only after the sequencer has left idle
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !s_tready)
    else $error("result loaded from idle");
`endif

endmodule

@@ rtl/fcg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_ctrl
// Sequencer: accepts one word, steps the datapath through selection, the
// multiply program, angle reduction, CORDIC, pixel mapping and result load.
// ----------------------------------------------------------------------------
module fcg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  fcg_pkg::stat_t stat,
  output fcg_pkg::cmd_t  cmd
);
  import fcg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEL  = 4'd1;
  localparam logic [3:0] S_MAC1 = 4'd2;
  localparam logic [3:0] S_MODI = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_FOLD = 4'd5;
  localparam logic [3:0] S_CORD = 4'd6;
  localparam logic [3:0] S_MAC2 = 4'd7;
  localparam logic [3:0] S_LOCX = 4'd8;
  localparam logic [3:0] S_LOCY = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]        state, state_next;
  logic [MAP_W-1:0]  k, k_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [2:0]        mk, mk_next;
  logic [STEP_W-1:0] ci, ci_next;
  logic              out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    pc_next    = pc;
    mk_next    = mk;
    ci_next    = ci;
    cmd        = '0;
    cmd.sel_k    = k;
    cmd.pc       = pc;
    cmd.mod_k    = mk;
    cmd.cordic_i = ci;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          k_next    = '0;
          state_next = (stat.func == FN_ITER) ? S_SEL : S_LOCX;
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        if (stat.sel_hit || (32'(k) == NUM_MAPS - 1)) begin
          pc_next    = '0;
          state_next = S_MAC1;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_MAC1: begin
        cmd.mac_en = 1'b1;
        if (pc == PC_W'(MAC1_LAST)) state_next = S_MODI;
        else pc_next = pc + 1'b1;
      end
      S_MODI: begin
        cmd.mod_init = 1'b1;
        mk_next      = 3'(MOD_STEPS - 1);
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (mk == 3'd0) state_next = S_FOLD;
        else mk_next = mk - 1'b1;
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        ci_next    = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (ci == STEP_W'(CORDIC_STEPS - 1)) begin
          pc_next    = PC_W'(MAC2_FIRST);
          state_next = S_MAC2;
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      S_MAC2: begin
        cmd.mac_en = 1'b1;
        if (pc == PC_W'(MAC2_LAST)) state_next = S_LOCX;
        else pc_next = pc + 1'b1;
      end
      S_LOCX: begin
        cmd.loc_x  = 1'b1;
        state_next = S_LOCY;
      end
      S_LOCY: begin
        cmd.loc_y  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      pc        <= '0;
      mk        <= '0;
      ci        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      pc    <= pc_next;
      mk    <= mk_next;
      ci    <= ci_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/fcg_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_dpath
// Datapath: map table, registers, one 32x32 multiplier with accumulator,
// modulo-2pi reducer, CORDIC rotator, pixel mapper and output register.
// ----------------------------------------------------------------------------
module fcg_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  fcg_pkg::cmd_t        cmd,
  output fcg_pkg::stat_t       stat,
  input  logic [1:0]           in_func,
  input  fcg_pkg::in_item_t    in_item,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output fcg_pkg::out_item_t   out_item
);
  import fcg_pkg::*;

  // Configuration
  logic signed [31:0] swirl_w, ident_w;
  logic [12:0]        img_w, img_h;

  // Map table
  logic [15:0]        prob  [NUM_MAPS];
  logic [23:0]        color [NUM_MAPS];
  logic signed [31:0] coef  [COEF_N];

  // Running state and item latches
  logic signed [31:0] cur_x, cur_y;
  logic [23:0]        cur_color;
  logic [MAP_W-1:0]   chosen;
  logic [1:0]         func;
  logic signed [19:0] rem;
  logic [23:0]        under;

  // Arithmetic registers
  logic signed [31:0] fx, fy, r, sx, sy;
  logic signed [63:0] prod;
  logic signed [47:0] acc, acc_next;
  logic [31:0]        mag;
  logic               mneg;
  logic signed [31:0] z;
  logic signed [33:0] cx, cy;
  logic               negc;

  // Pixel mapping registers
  logic               okx, on_image;
  logic [11:0]        colx, pix_col, pix_row;

  uop_t               u;
  logic signed [31:0] coef_rd, opa, opb, s_w, c_w;
  logic signed [47:0] p48, k48;
  logic [COEF_W-1:0]  coef_addr, load_addr;
  logic               load_ok;

  assign u = prog(cmd.pc);
  assign coef_addr = COEF_W'(32'(chosen) * 6 + 32'(u.kn));
  assign coef_rd   = coef[coef_addr];
  assign load_ok   = 32'(in_item.entry) < NUM_MAPS;
  assign load_addr = COEF_W'(32'(in_item.entry) * 6 + 32'(in_item.slot) - 1);

  // kind of the word on the input, for the branch taken at accept
  assign stat.func    = in_func;
  assign stat.sel_hit = $signed({4'b0, prob[cmd.sel_k]}) >= rem;

  // Sine and cosine from the rotated vector
  assign s_w = sat34(cy);
  assign c_w = sat34(negc ? -cx : cx);

  // Select multiplier operands
  always_comb begin
    opa = coef_rd;
    opb = cur_x;
    case (u.mul)
      M_AX:    begin opa = coef_rd; opb = cur_x;   end
      M_BY:    begin opa = coef_rd; opb = cur_y;   end
      M_DX:    begin opa = coef_rd; opb = cur_x;   end
      M_EY:    begin opa = coef_rd; opb = cur_y;   end
      M_FXFY:  begin opa = fx;      opb = fy;      end
      M_RR:    begin opa = r;       opb = r;       end
      M_FXS:   begin opa = fx;      opb = s_w;     end
      M_FYC:   begin opa = fy;      opb = c_w;     end
      M_FXC:   begin opa = fx;      opb = c_w;     end
      M_FYS:   begin opa = fy;      opb = s_w;     end
      M_SXW:   begin opa = sx;      opb = swirl_w; end
      M_FXI:   begin opa = fx;      opb = ident_w; end
      M_SYW:   begin opa = sy;      opb = swirl_w; end
      M_FYI:   begin opa = fy;      opb = ident_w; end
      default: begin opa = coef_rd; opb = cur_x;   end
    endcase
  end

  // Accumulate the floored Q8.24 product or a coefficient
  assign p48 = {{8{prod[63]}}, prod[63:24]};
  assign k48 = {{16{coef_rd[31]}}, coef_rd};
  always_comb begin
    case (u.op)
      A_P:     acc_next = p48;
      A_ADDP:  acc_next = acc + p48;
      A_SUBP:  acc_next = acc - p48;
      A_ADDK:  acc_next = acc + k48;
      default: acc_next = acc;
    endcase
  end

  // Angle fold into [-pi/2, pi/2]
  logic signed [31:0] zz, z1, zf;
  logic               fneg;
  always_comb begin
    zz   = (mneg && (mag != 32'd0)) ? (TWO_PI_Q - $signed(mag)) : $signed(mag);
    z1   = (zz > PI_Q) ? (zz - TWO_PI_Q) : zz;
    zf   = z1;
    fneg = 1'b0;
    if (z1 > HALF_PI_Q) begin
      zf   = PI_Q - z1;
      fneg = 1'b1;
    end else if (z1 < -HALF_PI_Q) begin
      zf   = -PI_Q - z1;
      fneg = 1'b1;
    end
  end

  // Pixel index of one axis
  logic [12:0]        loc_s;
  logic signed [32:0] loc_v;
  logic signed [46:0] loc_t;
  logic [21:0]        loc_idx;
  logic               loc_ok;
  always_comb begin
    loc_s   = cmd.loc_y ? img_h : img_w;
    if (loc_s > 13'd4096) loc_s = 13'd4096;
    loc_v   = (cmd.loc_y ? {cur_y[31], cur_y} : {cur_x[31], cur_x}) + Q_ONE;
    loc_t   = $signed({1'b0, loc_s}) * loc_v;
    loc_idx = loc_t[46] ? 22'd0 : loc_t[46:25];
    loc_ok  = (loc_t > -47'sd33554432) && (loc_idx < {9'd0, loc_s});
  end

  function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b);
    logic [8:0] rs, gs, bs;
    rs = {1'b0, a[23:16]} + {1'b0, b[23:16]};
    gs = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
    bs = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
    return {rs[8:1], gs[8:1], bs[8:1]};
  endfunction

  logic [23:0] under_eff;
  assign under_eff = on_image ? under : 24'd0;

  // Configuration, table and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      swirl_w   <= 32'sd8388608;
      ident_w   <= 32'sd8388608;
      img_w     <= 13'd500;
      img_h     <= 13'd500;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_color <= '0;
      chosen    <= '0;
      for (int i = 0; i < NUM_MAPS; i++) begin
        prob[i]  <= '0;
        color[i] <= '0;
      end
      for (int i = 0; i < COEF_N; i++) coef[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWIRL:    swirl_w <= cfg_data;
          CFG_IDENTITY: ident_w <= cfg_data;
          CFG_WIDTH:    img_w   <= cfg_data[12:0];
          CFG_HEIGHT:   img_h   <= cfg_data[12:0];
          default:      ;
        endcase
      end
      // take a load or start word
      if (cmd.latch && (in_func == FN_LOAD) && load_ok) begin
        if (in_item.slot == SLOT_PROB) prob[MAP_W'(in_item.entry)] <= in_item.word[15:0];
        else if (in_item.slot == SLOT_COLOR)
          color[MAP_W'(in_item.entry)] <= in_item.word[23:0];
        else coef[load_addr] <= in_item.word;
      end
      if (cmd.latch && (in_func == FN_START)) begin
        cur_x <= in_item.coord_x;
        cur_y <= in_item.coord_y;
      end
      // pick the map; entry 0 when the scan runs out
      if (cmd.sel_step) begin
        if (stat.sel_hit) chosen <= cmd.sel_k;
        else if (32'(cmd.sel_k) == NUM_MAPS - 1) chosen <= '0;
      end
      if (cmd.mac_en && (u.dest == D_X)) cur_x <= sat48(acc_next);
      if (cmd.mac_en && (u.dest == D_Y)) cur_y <= sat48(acc_next);
      // update the running color
      if (cmd.fin) begin
        case (func)
          FN_START:  cur_color <= under_eff;
          FN_ITER:   cur_color <= blend(color[chosen], cur_color);
          FN_FINISH: cur_color <= blend(under_eff, cur_color);
          default:   ;
        endcase
      end
    end
  end

  // Item latches and arithmetic work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func  <= in_func;
      rem   <= $signed({4'b0, in_item.rand_u});
      under <= {in_item.under_red, in_item.under_green, in_item.under_blue};
    end
    if (cmd.sel_step && !stat.sel_hit) rem <= rem - $signed({4'b0, prob[cmd.sel_k]});
    if (cmd.mac_en) begin
      if (u.mul != M_NONE) prod <= opa * opb;
      acc <= acc_next;
      case (u.dest)
        D_FX:    fx <= sat48(acc_next);
        D_FY:    fy <= sat48(acc_next);
        D_R:     r  <= sat48(acc_next);
        D_SX:    sx <= sat48(acc_next);
        D_SY:    sy <= sat48(acc_next);
        default: ;
      endcase
    end
    // reduce |r2| by shifted multiples of 2pi
    if (cmd.mod_init) begin
      mneg <= r[31];
      mag  <= r[31] ? (~r + 32'd1) : r;
    end
    if (cmd.mod_step) begin
      if (mag >= (32'(TWO_PI_Q) << cmd.mod_k)) mag <= mag - (32'(TWO_PI_Q) << cmd.mod_k);
    end
    if (cmd.fold) begin
      z    <= zf;
      negc <= fneg;
      cx   <= CORDIC_GAIN_Q;
      cy   <= '0;
    end
    // one rotation step
    if (cmd.cordic_step) begin
      if (!z[31]) begin
        cx <= cx - (cy >>> cmd.cordic_i);
        cy <= cy + (cx >>> cmd.cordic_i);
        z  <= z - atan_q(6'(cmd.cordic_i));
      end else begin
        cx <= cx + (cy >>> cmd.cordic_i);
        cy <= cy - (cx >>> cmd.cordic_i);
        z  <= z + atan_q(6'(cmd.cordic_i));
      end
    end
    // map point to pixel, x then y
    if (cmd.loc_x) begin
      okx  <= loc_ok;
      colx <= loc_idx[11:0];
    end
    if (cmd.loc_y) begin
      on_image <= okx && loc_ok;
      pix_col  <= (okx && loc_ok) ? colx : 12'd0;
      pix_row  <= (okx && loc_ok) ? loc_idx[11:0] : 12'd0;
    end
    // hold the result word
    if (cmd.out_load) begin
      out_item.point_x      <= cur_x;
      out_item.point_y      <= cur_y;
      out_item.pixel_col    <= pix_col;
      out_item.pixel_row    <= pix_row;
      out_item.on_image     <= on_image;
      out_item.chosen_entry <= 2'(chosen);
      out_item.out_red      <= cur_color[23:16];
      out_item.out_green    <= cur_color[15:8];
      out_item.out_blue     <= cur_color[7:0];
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the chaos-game step engine: random map tables, start, iterate and
// finish words are streamed in with random gaps and output stalls, and every
// result word is compared against a cycle-free model of the point, pixel and
// colour arithmetic.
// ----------------------------------------------------------------------------
module tb;
  import fcg_pkg::*;

  localparam int LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = FN_LOAD;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = CFG_SWIRL;
  logic [31:0]  cfg_data = '0;

  typedef struct {
    logic [1:0] fn;
    in_item_t   body;
  } word_t;

  word_t     send_q[$];
  out_item_t result_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        sent = 0;
  int        hold_off = 0;
  int        gap = 0;
  int        stall = 0;
  bit        in_flight = 0;

  // model state
  logic [15:0]        m_prob[NUM_MAPS];
  logic signed [31:0] m_coef[NUM_MAPS*6];
  logic [23:0]        m_color[NUM_MAPS];
  logic signed [31:0] m_x, m_y;
  logic [23:0]        m_rgb;
  logic [1:0]         m_last;
  logic signed [31:0] m_swirl, m_ident;
  logic [12:0]        m_w, m_h;

  flame_chaos_game_step u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floor shift by 24
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 24;
  endfunction

  function automatic logic signed [63:0] arctan(input int i);
    int head[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                    262123, 131069};
    if (i < 8) return head[i];
    if (i <= 24) return 64'sd1 <<< (24 - i);
    return 0;
  endfunction

  function automatic void sin_cos(input logic signed [31:0] ang,
                                  output logic signed [31:0] s,
                                  output logic signed [31:0] c);
    logic signed [63:0] z, cx, cy, xs, ys;
    bit flip;
    z = 64'(ang) % 64'sd105414357;
    flip = 0;
    cx = 64'sd10188014;
    cy = 0;
    if (z < 0) z += 105414357;
    if (z > 52707179) z -= 105414357;
    if (z > 26353589) begin
      z = 52707179 - z;
      flip = 1;
    end else if (z < -26353589) begin
      z = -52707179 - z;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys; cy += xs; z -= arctan(i);
      end else begin
        cx += ys; cy -= xs; z += arctan(i);
      end
    end
    s = 32'(sat(cy));
    c = 32'(sat(flip ? -cx : cx));
  endfunction

  function automatic bit pixel_axis(input logic signed [31:0] v, input logic [12:0] sz,
                                    output logic [11:0] idx);
    logic signed [63:0] t;
    logic [63:0] n, size;
    size = (sz > 13'd4096) ? 64'd4096 : 64'(sz);
    t = 64'(size) * (64'(v) + 64'sd16777216);
    idx = '0;
    if (t <= -(64'sd1 <<< 25)) return 0;
    n = (t >= 0) ? (t >>> 25) : 64'd0;
    idx = n[11:0];
    return n < size;
  endfunction

  function automatic bit locate(output logic [11:0] col, output logic [11:0] row);
    logic [11:0] c, r;
    bit ok;
    ok = pixel_axis(m_x, m_w, c);
    if (ok) ok = pixel_axis(m_y, m_h, r);
    col = ok ? c : 12'd0;
    row = ok ? r : 12'd0;
    return ok;
  endfunction

  function automatic logic [23:0] average(input logic [23:0] a, input logic [23:0] b);
    logic [8:0] r, g, bl;
    r = (a[23:16] + b[23:16]) >> 1;
    g = (a[15:8] + b[15:8]) >> 1;
    bl = (a[7:0] + b[7:0]) >> 1;
    return {r[7:0], g[7:0], bl[7:0]};
  endfunction

  function automatic out_item_t advance_point(input word_t w);
    out_item_t o;
    logic [11:0] col, row;
    logic [23:0] under;
    logic signed [31:0] rem, fx, fy, r, s, c, sx, sy;
    int j, k;
    under = {w.body.under_red, w.body.under_green, w.body.under_blue};
    case (w.fn)
      FN_LOAD: begin
        if (w.body.slot == SLOT_PROB) m_prob[w.body.entry] = w.body.word[15:0];
        else if (w.body.slot == SLOT_COLOR) m_color[w.body.entry] = w.body.word[23:0];
        else m_coef[w.body.entry*6 + w.body.slot - 1] = w.body.word;
      end
      FN_START: begin
        m_x = w.body.coord_x;
        m_y = w.body.coord_y;
        m_rgb = locate(col, row) ? under : 24'd0;
      end
      FN_ITER: begin
        rem = $signed({16'd0, w.body.rand_u});
        j = 0;
        for (int i = 0; i < NUM_MAPS; i++) begin
          if ($signed({16'd0, m_prob[i]}) >= rem) begin
            j = i;
            break;
          end
          rem -= $signed({16'd0, m_prob[i]});
        end
        k = j * 6;
        fx = 32'(sat(qmul(m_coef[k], m_x) + qmul(m_coef[k+1], m_y) + m_coef[k+2]));
        fy = 32'(sat(qmul(m_coef[k+3], m_x) + qmul(m_coef[k+4], m_y) + m_coef[k+5]));
        r = 32'(sat(qmul(fx, fy)));
        r = 32'(sat(qmul(r, r)));
        sin_cos(r, s, c);
        sx = 32'(sat(qmul(fx, s) - qmul(fy, c)));
        sy = 32'(sat(qmul(fx, c) + qmul(fy, s)));
        m_x = 32'(sat(qmul(sx, m_swirl) + qmul(fx, m_ident)));
        m_y = 32'(sat(qmul(sy, m_swirl) + qmul(fy, m_ident)));
        m_rgb = average(m_color[j], m_rgb);
        m_last = 2'(j);
      end
      default: begin
        m_rgb = average(locate(col, row) ? under : 24'd0, m_rgb);
      end
    endcase
    o.on_image = locate(col, row);
    o.pixel_col = col;
    o.pixel_row = row;
    o.point_x = m_x;
    o.point_y = m_y;
    o.chosen_entry = m_last;
    o.out_red = m_rgb[23:16];
    o.out_green = m_rgb[15:8];
    o.out_blue = m_rgb[7:0];
    return o;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216;
    endcase
  endfunction

  function automatic word_t make_word(input logic [1:0] fn);
    word_t w;
    w.fn = fn;
    w.body.entry = 2'($urandom_range(0, 3));
    w.body.slot = 3'($urandom_range(0, 7));
    w.body.word = $urandom;
    w.body.coord_x = $urandom;
    w.body.coord_y = $urandom;
    w.body.rand_u = 16'($urandom);
    w.body.under_red = 8'($urandom);
    w.body.under_green = 8'($urandom);
    w.body.under_blue = 8'($urandom);
    return w;
  endfunction

  task automatic queue_word(input word_t w);
    send_q.push_back(w);
  endtask

  task automatic queue_table();
    word_t w;
    for (int e = 0; e < NUM_MAPS; e++)
      for (int sl = 0; sl < 8; sl++) begin
        w = make_word(FN_LOAD);
        w.body.entry = 2'(e);
        w.body.slot = 3'(sl);
        if (sl == SLOT_PROB) w.body.word = {$urandom_range(0, 65535) >> $urandom_range(0, 3)};
        else if (sl != SLOT_COLOR) w.body.word = rand_coef();
        queue_word(w);
      end
  endtask

  // random chaos-game run: optional table reload, start, iterates with stray load words, optional finish
  task automatic queue_run();
    word_t w;
    if ($urandom_range(0, 3) == 0) queue_table();
    w = make_word(FN_START);
    if ($urandom_range(0, 3) != 0) begin
      w.body.coord_x = $signed(32'($urandom_range(0, 40000000))) - 32'sd20000000;
      w.body.coord_y = $signed(32'($urandom_range(0, 40000000))) - 32'sd20000000;
    end
    queue_word(w);
    repeat ($urandom_range(1, 8)) begin
      w = make_word(FN_ITER);
      if ($urandom_range(0, 7) == 0) begin
        w = make_word(FN_LOAD);
      end
      queue_word(w);
    end
    if ($urandom_range(0, 4) != 0) queue_word(make_word(FN_FINISH));
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SWIRL: m_swirl = val;
      CFG_IDENTITY: m_ident = val;
      CFG_WIDTH: m_w = val[12:0];
      default: m_h = val[12:0];
    endcase
  endtask

  task automatic drain();
    wait (send_q.size() == 0 && !in_flight && result_q.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(advance_point(send_q.pop_front()));
        sent++;
        gap = pick_gap();
      end
      if (s_tvalid && !s_tready) begin
        // hold the word
      end else if (gap > 0) begin
        gap--;
        s_tvalid <= 1'b0;
        in_flight = 0;
      end else if (send_q.size() > (s_tvalid && s_tready ? 0 : 0)) begin
        s_tvalid <= 1'b1;
        s_tuser <= send_q[0].fn;
        s_tdata <= {3'd0, send_q[0].body};
        in_flight = 1;
      end else begin
        s_tvalid <= 1'b0;
        in_flight = 0;
      end
    end
  end

  // count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_off > 0) hold_off--;
  end

  // output monitor and checker
  always @(posedge clk) begin
    out_item_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(out_item_t)-1:0];
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.point_x !== want.point_x) begin
            $error("point_x exp %0h got %0h", want.point_x, got.point_x); errors++;
          end
          if (got.point_y !== want.point_y) begin
            $error("point_y exp %0h got %0h", want.point_y, got.point_y); errors++;
          end
          if (got.pixel_col !== want.pixel_col) begin
            $error("pixel_col exp %0d got %0d", want.pixel_col, got.pixel_col); errors++;
          end
          if (got.pixel_row !== want.pixel_row) begin
            $error("pixel_row exp %0d got %0d", want.pixel_row, got.pixel_row); errors++;
          end
          if (got.on_image !== want.on_image) begin
            $error("on_image exp %0d got %0d", want.on_image, got.on_image); errors++;
          end
          if (got.chosen_entry !== want.chosen_entry) begin
            $error("chosen_entry exp %0d got %0d", want.chosen_entry, got.chosen_entry);
            errors++;
          end
          if (got.out_red !== want.out_red) begin
            $error("out_red exp %0d got %0d", want.out_red, got.out_red); errors++;
          end
          if (got.out_green !== want.out_green) begin
            $error("out_green exp %0d got %0d", want.out_green, got.out_green); errors++;
          end
          if (got.out_blue !== want.out_blue) begin
            $error("out_blue exp %0d got %0d", want.out_blue, got.out_blue); errors++;
          end
        end
      end
      // receiver stalls, with one long hold-off on request
      if (hold_off > 0) begin
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    word_t w;
    for (int i = 0; i < NUM_MAPS; i++) begin
      m_prob[i] = 0;
      m_color[i] = 0;
    end
    for (int i = 0; i < NUM_MAPS*6; i++) m_coef[i] = 0;
    m_x = 0; m_y = 0; m_rgb = 0; m_last = 0;
    m_swirl = 32'sd8388608; m_ident = 32'sd8388608; m_w = 500; m_h = 500;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: iterate on empty table, edge points, every slot, finish
    queue_word(make_word(FN_ITER));
    w = make_word(FN_START);
    w.body.coord_x = 32'sh80000000; w.body.coord_y = 32'sh7fffffff;
    queue_word(w);
    w = make_word(FN_START);
    w.body.coord_x = -32'sd16777216; w.body.coord_y = 32'sd16777215;
    queue_word(w);
    queue_word(make_word(FN_FINISH));
    queue_table();
    w = make_word(FN_ITER); w.body.rand_u = 16'hffff; queue_word(w);
    w = make_word(FN_ITER); w.body.rand_u = 16'h0000; queue_word(w);
    w = make_word(FN_FINISH); queue_word(w);
    drain();

    // several register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_SWIRL, 32'h7fffffff); write_reg(CFG_IDENTITY, 32'h80000000);
          write_reg(CFG_WIDTH, 1); write_reg(CFG_HEIGHT, 4096);
        end
        1: begin
          write_reg(CFG_SWIRL, 32'h80000000); write_reg(CFG_IDENTITY, 32'h7fffffff);
          write_reg(CFG_WIDTH, 4096); write_reg(CFG_HEIGHT, 1);
        end
        2: begin
          write_reg(CFG_WIDTH, 0); write_reg(CFG_HEIGHT, 13'h1fff);
        end
        default: begin
          write_reg(CFG_SWIRL, $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216);
          write_reg(CFG_IDENTITY, $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216);
          write_reg(CFG_WIDTH, $urandom_range(1, 4096));
          write_reg(CFG_HEIGHT, $urandom_range(1, 4096));
        end
      endcase
      if (phase == 3) hold_off = 400;
      while (send_q.size() < 80) queue_run();
      drain();
    end

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

@@ flame_chaos_game_step.f @@
rtl/fcg_pkg.sv
rtl/fcg_ctrl.sv
rtl/fcg_dpath.sv
rtl/flame_chaos_game_step.sv
test/tb.sv
